// File: sv/sac_pkg.sv
// Shared geometry, request codes and record types of the cache tag engine.
package sac_pkg;

	localparam int ADDR_W      = 48;
	localparam int BLOCK_OFS_W = 6;
	localparam int SET_BITS    = 6;
	localparam int SETS        = 1 << SET_BITS;
	localparam int WAYS        = 4;
	localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int RANK_W      = WAY_W;
	localparam int TAG_W       = ADDR_W - BLOCK_OFS_W - SET_BITS;

	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

	localparam logic [1:0] REQ_READ     = 2'd0;
	localparam logic [1:0] REQ_WRITE    = 2'd1;
	localparam logic [1:0] REQ_PREFETCH = 2'd2;
	localparam logic [1:0] REQ_NONE     = 2'd3;

	typedef struct packed {
		logic [WAYS-1:0][TAG_W-1:0]  tag;
		logic [WAYS-1:0]             dirty;
		logic [WAYS-1:0]             pref;
		logic [WAYS-1:0][RANK_W-1:0] rank;
	} row_t;

	typedef struct packed {
		logic              hit;
		logic              prefetch_used;
		logic              fetch_valid;
		logic [ADDR_W-1:0] fetch_addr;
		logic              writeback_valid;
		logic [ADDR_W-1:0] writeback_addr;
	} result_t;

	typedef struct packed {
		logic            wr_en;
		row_t            row;
		logic [WAYS-1:0] valid;
	} upd_t;

endpackage

// File: sv/sac_ifs.sv
// Request, response and configuration channel interfaces of the cache tag engine.
interface sac_req_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                req_type;
	logic [sac_pkg::ADDR_W-1:0] req_addr;
	modport source (output valid, req_type, req_addr, input ready);
	modport sink (input valid, req_type, req_addr, output ready);
endinterface

interface sac_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      hit;
	logic                      prefetch_used;
	logic                      fetch_valid;
	logic [sac_pkg::ADDR_W-1:0] fetch_addr;
	logic                      writeback_valid;
	logic [sac_pkg::ADDR_W-1:0] writeback_addr;
	modport source (output valid, hit, prefetch_used, fetch_valid, fetch_addr,
		writeback_valid, writeback_addr, input ready);
	modport sink (input valid, hit, prefetch_used, fetch_valid, fetch_addr,
		writeback_valid, writeback_addr, output ready);
endinterface

interface sac_cfg_if;
	logic valid;
	logic ready;
	logic next_level_present;
	modport source (output valid, next_level_present, input ready);
	modport sink (input valid, next_level_present, output ready);
endinterface

// File: sv/sac_lookup.sv
// Tag compare, victim choice, recency update and result build for one set.
module sac_lookup (
	input  logic [1:0]                  req_type,
	input  logic [sac_pkg::ADDR_W-1:0]  req_addr,
	input  sac_pkg::row_t               row,
	input  logic [sac_pkg::WAYS-1:0]    line_valid,
	input  logic                        next_level_present,
	output sac_pkg::result_t            res,
	output sac_pkg::upd_t               upd
);
	import sac_pkg::*;

	logic [TAG_W-1:0]    tag;
	logic [SET_BITS-1:0] set_idx;
	logic                hit_any;
	logic                free_any;
	logic [WAY_W-1:0]    hit_way;
	logic [WAY_W-1:0]    free_way;
	logic [WAY_W-1:0]    victim;
	logic [WAY_W-1:0]    sel_way;
	logic [RANK_W-1:0]   old_rank;
	logic                is_write;
	logic                is_pf;
	logic                is_none;

	assign tag      = req_addr[ADDR_W-1 -: TAG_W];
	assign set_idx  = req_addr[BLOCK_OFS_W +: SET_BITS];
	assign is_write = (req_type == REQ_WRITE);
	assign is_pf    = (req_type == REQ_PREFETCH);
	assign is_none  = (req_type == REQ_NONE);

	always_comb begin
		hit_any  = 1'b0;
		free_any = 1'b0;
		hit_way  = '0;
		free_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (line_valid[w] && row.tag[w] == tag) begin
				hit_any = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (!line_valid[w] && !free_any) begin
				free_any = 1'b1;
				free_way = WAY_W'(w);
			end
		end
	end

	always_comb begin
		victim = '0;
		for (int w = 1; w < WAYS; w++) begin
			if (row.rank[w] > row.rank[victim]) begin
				victim = WAY_W'(w);
			end
		end
	end

	always_comb begin
		priority if (hit_any) begin
			sel_way = hit_way;
		end else if (free_any) begin
			sel_way = free_way;
		end else begin
			sel_way = victim;
		end
	end

	assign old_rank = line_valid[sel_way] ? row.rank[sel_way] : RANK_MAX;

	always_comb begin
		upd.row   = row;
		upd.valid = line_valid;
		upd.wr_en = !is_none && !(hit_any && is_pf);
		for (int w = 0; w < WAYS; w++) begin
			if (WAY_W'(w) != sel_way && line_valid[w] && row.rank[w] < old_rank &&
					row.rank[w] != RANK_MAX) begin
				upd.row.rank[w] = row.rank[w] + 1'b1;
			end
		end
		upd.row.rank[sel_way] = '0;
		if (hit_any) begin
			upd.row.dirty[sel_way] = row.dirty[sel_way] | is_write;
			upd.row.pref[sel_way]  = 1'b0;
		end else begin
			upd.valid[sel_way]     = 1'b1;
			upd.row.tag[sel_way]   = tag;
			upd.row.dirty[sel_way] = is_write;
			upd.row.pref[sel_way]  = is_pf;
		end
	end

	always_comb begin
		res = '0;
		if (!is_none) begin
			res.hit = hit_any;
			if (hit_any) begin
				res.prefetch_used = !is_pf && row.pref[hit_way];
			end else begin
				res.fetch_valid     = next_level_present;
				res.fetch_addr      = next_level_present ? req_addr : '0;
				res.writeback_valid = line_valid[sel_way] && row.dirty[sel_way] &&
					next_level_present;
				if (res.writeback_valid) begin
					res.writeback_addr = {row.tag[sel_way], set_idx, {BLOCK_OFS_W{1'b0}}};
				end
			end
		end
	end

endmodule

// File: sv/set_assoc_writeback_cache.sv
// Top level of the set-associative write-back cache tag and state engine.
//
//  channel | dir | beat carries
//  req     | in  | req_type, req_addr
//  rsp     | out | hit, prefetch_used, fetch/writeback valid and address
//  cfg     | in  | next_level_present
//
// One request per cycle unless rsp stalls; result goes via set read, then result register.
// The set row lives in a tag memory with one read and one write port, read on acceptance;
// a write to the same set by the preceding request is forwarded from a bypass register.
// Reset clears valid bits, pipeline and bypass, sets next_level_q; tag memory is not cleared.
// A stalled rsp holds the result register and the lookup stage, and req then waits.
module set_assoc_writeback_cache (
	input  logic       clk,
	input  logic       arst_n,
	sac_req_if.sink    req,
	sac_rsp_if.source  rsp,
	sac_cfg_if.sink    cfg
);
	import sac_pkg::*;

	row_t                          mem [SETS];
	row_t                          rd_row_s1;
	row_t                          wr_row_q;
	row_t                          row_cur;
	logic [SET_BITS-1:0]           wr_set_q;
	logic                          wr_vld_q;
	logic [SETS-1:0][WAYS-1:0]     line_valid_q;
	logic                          next_level_q;
	logic                          valid_s1;
	logic [1:0]                    type_s1;
	logic [ADDR_W-1:0]             addr_s1;
	logic [SET_BITS-1:0]           set_s1;
	logic [SET_BITS-1:0]           set_in;
	logic                          adv;
	logic                          accept;
	logic                          rsp_valid_q;
	result_t                       rsp_q;
	result_t                       res;
	upd_t                          upd;
	logic                          do_write;

	assign set_in    = req.req_addr[BLOCK_OFS_W +: SET_BITS];
	assign set_s1    = addr_s1[BLOCK_OFS_W +: SET_BITS];
	assign adv       = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || adv;
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;
	assign do_write  = valid_s1 && adv && upd.wr_en;
	assign row_cur   = (wr_vld_q && wr_set_q == set_s1) ? wr_row_q : rd_row_s1;

	sac_lookup u_lookup (
		.req_type           (type_s1),
		.req_addr           (addr_s1),
		.row                (row_cur),
		.line_valid         (line_valid_q[set_s1]),
		.next_level_present (next_level_q),
		.res                (res),
		.upd                (upd)
	);

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[set_s1] <= upd.row;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_row_s1 <= mem[set_in];
			type_s1   <= req.req_type;
			addr_s1   <= req.req_addr;
		end
		if (do_write) begin
			wr_row_q <= upd.row;
			wr_set_q <= set_s1;
		end
		if (valid_s1 && adv) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			rsp_valid_q  <= 1'b0;
			wr_vld_q     <= 1'b0;
			line_valid_q <= '0;
			next_level_q <= 1'b1;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv) begin
				rsp_valid_q <= valid_s1;
			end
			if (do_write) begin
				wr_vld_q             <= 1'b1;
				line_valid_q[set_s1] <= upd.valid;
			end
			if (cfg.valid && cfg.ready) begin
				next_level_q <= cfg.next_level_present;
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.hit             = rsp_q.hit;
	assign rsp.prefetch_used   = rsp_q.prefetch_used;
	assign rsp.fetch_valid     = rsp_q.fetch_valid;
	assign rsp.fetch_addr      = rsp_q.fetch_addr;
	assign rsp.writeback_valid = rsp_q.writeback_valid;
	assign rsp.writeback_addr  = rsp_q.writeback_addr;

	a_hit_no_traffic: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.hit |-> !rsp.fetch_valid && !rsp.writeback_valid)
		else $error("hit beat carries next-level traffic");

	a_wb_with_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.writeback_valid |-> rsp.fetch_valid)
		else $error("write-back without fetch");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(addr_s1) && $stable(type_s1))
		else $error("lookup stage moved under stall");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !do_write)
		else $error("set written with empty lookup stage");

endmodule
